/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the timer slot table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every clock edge outside reset.
`define MSTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MSTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/mstt_pkg.sv */
// Types, constants and codes of the timer slot table.
package mstt_pkg;
	localparam int SLOT_COUNT = 6;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int MAX_RESULTS = 7;
	localparam int FIRE_MAX = MAX_RESULTS - 1;
	localparam int FIRE_W = $clog2(FIRE_MAX + 1);

	typedef enum logic [3:0] {
		CMD_CREATE         = 4'd0,
		CMD_FREE_SLOT      = 4'd1,
		CMD_FREE_WINDOW    = 4'd2,
		CMD_TICK           = 4'd3,
		CMD_RESTART_SLOT   = 4'd4,
		CMD_SET_DELAY      = 4'd5,
		CMD_RESTART_WINDOW = 4'd6,
		CMD_QUERY_EXPIRED  = 4'd7,
		CMD_QUERY_TIMEOUT  = 4'd8
	} cmd_t;

	localparam logic [2:0] MODE_FREE     = 3'd0;
	localparam logic [2:0] MODE_ONESHOT  = 3'd1;
	localparam logic [2:0] MODE_PERIODIC = 3'd2;
	localparam logic [2:0] MODE_TIMEOUT  = 3'd3;
	localparam logic [2:0] MODE_TXTROLL  = 3'd4;

	localparam logic [1:0] KIND_REPLY     = 2'd0;
	localparam logic [1:0] KIND_FIRED     = 2'd1;
	localparam logic [1:0] KIND_TICK_DONE = 2'd2;
	localparam logic [1:0] KIND_QUERY     = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;
	localparam logic [1:0] STAT_RUNNING = 2'd0;
	localparam logic [1:0] STAT_EXPIRED = 2'd1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] start;
		logic [23:0] delay;
		logic [15:0] window;
	} entry_t;

	typedef struct packed {
		logic       wr_en;
		entry_t     wr_data;
		logic       clear;
		logic       tmo_clear;
		logic       match;
		logic       fire;
		logic [1:0] qstat;
	} eval_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [15:0] window;
		logic [1:0]  status;
		logic        found;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_REPLY
	} state_t;
endpackage

/* hdl/mstt_slot_eval.sv */
// Per-slot update rule: decides the write-back and events for one slot read from the table.
module mstt_slot_eval (
	input  mstt_pkg::cmd_t   cmd,
	input  mstt_pkg::entry_t entry,
	input  logic             used,
	input  logic [31:0]      now_ms,
	input  logic [15:0]      win,
	input  logic [23:0]      dly,
	input  logic             matched,
	output mstt_pkg::eval_t  ev
);
	logic        hit_win;
	logic        due;
	logic [31:0] elapsed;

	assign hit_win = used && (entry.window == win);
	assign elapsed = now_ms - entry.start;
	assign due = used && (entry.delay != 24'd0) && ({8'd0, entry.delay} <= elapsed);

	always_comb begin
		ev = '0;
		ev.wr_data = entry;
		ev.qstat = used ? ((entry.delay == 24'd0) ? mstt_pkg::STAT_EXPIRED
			: mstt_pkg::STAT_RUNNING) : mstt_pkg::STAT_INVALID;
		unique case (cmd)
			mstt_pkg::CMD_FREE_SLOT: begin
				ev.clear = used;
				ev.tmo_clear = used && (entry.mode == mstt_pkg::MODE_TIMEOUT);
			end
			mstt_pkg::CMD_FREE_WINDOW: begin
				ev.clear = hit_win;
				ev.tmo_clear = hit_win && (entry.mode == mstt_pkg::MODE_TIMEOUT);
			end
			mstt_pkg::CMD_TICK: begin
				if (due) begin
					ev.wr_en = 1'b1;
					unique case (entry.mode)
						mstt_pkg::MODE_ONESHOT: begin
							ev.wr_data.delay = 24'd0;
							ev.fire = 1'b1;
						end
						mstt_pkg::MODE_PERIODIC: begin
							ev.wr_data.start = entry.start + {8'd0, entry.delay};
							ev.fire = 1'b1;
						end
						mstt_pkg::MODE_TIMEOUT: begin
							ev.wr_data.delay = 24'd0;
						end
						default: begin
							ev.wr_data.start = now_ms;
							ev.fire = 1'b1;
						end
					endcase
				end
			end
			mstt_pkg::CMD_RESTART_SLOT: begin
				ev.wr_en = used;
				ev.wr_data.start = now_ms;
			end
			mstt_pkg::CMD_SET_DELAY: begin
				ev.match = hit_win && !matched;
				ev.wr_en = hit_win && !matched;
				ev.wr_data.delay = dly;
			end
			mstt_pkg::CMD_RESTART_WINDOW: begin
				ev.match = hit_win && !matched;
				ev.wr_en = hit_win && !matched;
				ev.wr_data.start = now_ms;
			end
			default: begin
			end
		endcase
	end
endmodule

/* hdl/multi_slot_software_timer_table_top.sv */
// Timer slot table: command decode, table scan over a registered-read RAM, result register.
// Create, timeout query, unknown and out-of-range slot commands: result in the cycle after transfer.
// Slot commands scan their one slot; table-wide commands and tick scan every slot, in a sequential
// read-modify-write scan of one slot per cycle through the slot RAM, then pass ST_WAIT and ST_REPLY.
// A tick gives up to SLOT_COUNT fired results, one per cycle, then the tick-done result.
// Reset clears time, valid bits of all slots and the timeout record; results cannot be stalled.
`include "assert_macros.svh"

module multi_slot_software_timer_table_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         command,
	input  logic [2:0]         mode,
	input  logic [23:0]        delay_ms,
	input  logic signed [15:0] window,
	input  logic [2:0]         slot,
	output logic               strobe,
	output logic [1:0]         kind,
	output logic [2:0]         slot_out,
	output logic signed [15:0] window_out,
	output logic [1:0]         status,
	output logic               found,
	output logic               last
);
	localparam int IW = mstt_pkg::IDX_W;

	mstt_pkg::entry_t  mem [mstt_pkg::SLOT_COUNT];
	mstt_pkg::entry_t  rd_data_s1;
	mstt_pkg::entry_t  mem_wd;
	mstt_pkg::eval_t   ev;
	mstt_pkg::result_t imm, fin, fev, out_d, res_q;
	mstt_pkg::state_t  state_q, state_d;
	mstt_pkg::cmd_t    cmd_in, cmd_q;

	logic [mstt_pkg::SLOT_COUNT-1:0] used_q;
	logic [31:0]              now_q;
	logic                     tmo_valid_q;
	logic [IW-1:0]            tmo_slot_q;
	logic [IW-1:0]            idx_q, end_q, idx_s1, free_idx, match_idx_q, mem_wa;
	logic                     valid_s1, strobe_q, matched_q;
	logic [mstt_pkg::FIRE_W-1:0] nfire_q;
	logic [23:0]              dly_q;
	logic [15:0]              win_q;
	logic [2:0]               sl_q;
	logic [1:0]               qstat_q;
	logic                     acc, rd_en, free_ok, mode_ok, slot_ok, slot_cmd, scan_need;
	logic                     create_we, mem_we, fire_emit, out_set;

	assign cmd_in = mstt_pkg::cmd_t'(command);
	assign acc = start && !busy;
	assign mode_ok = (mode >= mstt_pkg::MODE_ONESHOT) && (mode <= mstt_pkg::MODE_TXTROLL);
	assign slot_ok = (4'(slot) < 4'(mstt_pkg::SLOT_COUNT));

	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = mstt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_ok = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// immediate replies and scan setup
	always_comb begin
		imm = '0;
		imm.last = 1'b1;
		create_we = 1'b0;
		scan_need = 1'b0;
		slot_cmd = 1'b0;
		unique case (cmd_in)
			mstt_pkg::CMD_CREATE: begin
				if (!mode_ok) begin
					imm.status = mstt_pkg::STAT_INVALID;
				end else if (!free_ok) begin
					imm.status = mstt_pkg::STAT_FULL;
				end else begin
					create_we = 1'b1;
					imm.status = mstt_pkg::STAT_OK;
					imm.slot = 3'(free_idx);
				end
			end
			mstt_pkg::CMD_FREE_SLOT, mstt_pkg::CMD_RESTART_SLOT: begin
				slot_cmd = 1'b1;
				scan_need = slot_ok;
				imm.slot = slot;
			end
			mstt_pkg::CMD_QUERY_EXPIRED: begin
				slot_cmd = 1'b1;
				scan_need = slot_ok;
				imm.kind = mstt_pkg::KIND_QUERY;
				imm.slot = slot;
				imm.status = mstt_pkg::STAT_INVALID;
			end
			mstt_pkg::CMD_FREE_WINDOW, mstt_pkg::CMD_TICK,
			mstt_pkg::CMD_SET_DELAY, mstt_pkg::CMD_RESTART_WINDOW: begin
				scan_need = 1'b1;
			end
			mstt_pkg::CMD_QUERY_TIMEOUT: begin
				imm.kind = mstt_pkg::KIND_QUERY;
				imm.slot = tmo_valid_q ? 3'(tmo_slot_q) : 3'd0;
				imm.found = tmo_valid_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mstt_pkg::ST_IDLE:  if (acc && scan_need) state_d = mstt_pkg::ST_SCAN;
			mstt_pkg::ST_SCAN:  if (idx_q == end_q) state_d = mstt_pkg::ST_WAIT;
			mstt_pkg::ST_WAIT:  state_d = mstt_pkg::ST_REPLY;
			mstt_pkg::ST_REPLY: state_d = mstt_pkg::ST_IDLE;
			default:            state_d = mstt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != mstt_pkg::ST_IDLE);
		rd_en = (state_q == mstt_pkg::ST_SCAN);
	end

	mstt_slot_eval u_eval (
		.cmd     (cmd_q),
		.entry   (rd_data_s1),
		.used    (used_q[idx_s1]),
		.now_ms  (now_q),
		.win     (win_q),
		.dly     (dly_q),
		.matched (matched_q),
		.ev      (ev)
	);

	assign fire_emit = valid_s1 && ev.fire && (nfire_q < mstt_pkg::FIRE_W'(mstt_pkg::FIRE_MAX));

	always_comb begin
		fin = '0;
		fin.last = 1'b1;
		unique case (cmd_q)
			mstt_pkg::CMD_TICK: fin.kind = mstt_pkg::KIND_TICK_DONE;
			mstt_pkg::CMD_FREE_SLOT, mstt_pkg::CMD_RESTART_SLOT: fin.slot = sl_q;
			mstt_pkg::CMD_SET_DELAY, mstt_pkg::CMD_RESTART_WINDOW:
				fin.slot = matched_q ? 3'(match_idx_q) : 3'd0;
			mstt_pkg::CMD_QUERY_EXPIRED: begin
				fin.kind = mstt_pkg::KIND_QUERY;
				fin.slot = sl_q;
				fin.status = qstat_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		fev = '0;
		fev.kind = mstt_pkg::KIND_FIRED;
		fev.slot = 3'(idx_s1);
		fev.window = rd_data_s1.window;
	end

	always_comb begin
		out_set = 1'b1;
		out_d = fin;
		priority if (acc && !scan_need) begin
			out_d = imm;
		end else if (fire_emit) begin
			out_d = fev;
		end else if (state_q == mstt_pkg::ST_REPLY) begin
			out_d = fin;
		end else begin
			out_set = 1'b0;
		end
	end

	always_comb begin
		mem_we = (acc && create_we) || (valid_s1 && ev.wr_en);
		if (acc && create_we) begin
			mem_wa = free_idx;
			mem_wd = '{mode: mode, start: now_q, delay: delay_ms, window: window};
		end else begin
			mem_wa = idx_s1;
			mem_wd = ev.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mstt_pkg::ST_IDLE;
			now_q <= '0;
			tmo_valid_q <= 1'b0;
			used_q <= '0;
			valid_s1 <= 1'b0;
			strobe_q <= 1'b0;
			matched_q <= 1'b0;
			nfire_q <= '0;
		end else begin
			state_q <= state_d;
			valid_s1 <= rd_en;
			strobe_q <= out_set;
			if (acc) begin
				matched_q <= 1'b0;
				nfire_q <= '0;
				if (cmd_in == mstt_pkg::CMD_TICK) now_q <= now_q + 32'd1;
				if (create_we) used_q[free_idx] <= 1'b1;
				if (cmd_in == mstt_pkg::CMD_CREATE && mode == mstt_pkg::MODE_TIMEOUT)
					tmo_valid_q <= free_ok;
			end
			if (valid_s1) begin
				if (ev.clear) used_q[idx_s1] <= 1'b0;
				if (ev.tmo_clear) tmo_valid_q <= 1'b0;
				if (ev.match) matched_q <= 1'b1;
				if (fire_emit) nfire_q <= nfire_q + mstt_pkg::FIRE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= cmd_in;
			dly_q <= delay_ms;
			win_q <= window;
			sl_q <= slot;
			idx_q <= slot_cmd ? slot[IW-1:0] : '0;
			end_q <= slot_cmd ? slot[IW-1:0] : IW'(mstt_pkg::SLOT_COUNT - 1);
			if (create_we && mode == mstt_pkg::MODE_TIMEOUT) tmo_slot_q <= free_idx;
		end else if (rd_en) begin
			idx_q <= idx_q + IW'(1);
		end
		idx_s1 <= idx_q;
		if (valid_s1 && ev.match) match_idx_q <= idx_s1;
		if (valid_s1 && cmd_q == mstt_pkg::CMD_QUERY_EXPIRED) qstat_q <= ev.qstat;
		if (out_set) res_q <= out_d;
	end

	assign strobe = strobe_q;
	assign kind = res_q.kind;
	assign slot_out = res_q.slot;
	assign window_out = res_q.window;
	assign status = res_q.status;
	assign found = res_q.found;
	assign last = res_q.last;

	`MSTT_ASSERT(a_final_when_idle, (strobe && last) |-> !busy, "final result while busy")
	`MSTT_ASSERT(a_fired_in_scan, (strobe && !last) |-> (busy && kind == mstt_pkg::KIND_FIRED),
		"fired result outside a tick scan")
	`MSTT_ASSERT(a_s1_in_scan, valid_s1 |->
		(state_q == mstt_pkg::ST_SCAN || state_q == mstt_pkg::ST_WAIT), "stray table read")
	`MSTT_ASSERT(a_create_free, (acc && create_we) |-> !used_q[free_idx],
		"create writes a used slot")
	`MSTT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!strobe && !busy), "activity in reset")
endmodule
